@@ design/pts_pkg.sv @@
// Shared types and constants for the priority task scheduler.
`timescale 1ns / 1ps

package pts_pkg;

   localparam int TASKS           = 8;
   localparam int PRIORITY_LEVELS = 32;
   localparam int IDX_W           = $clog2(TASKS);
   localparam int PRIO_W          = $clog2(PRIORITY_LEVELS);
   localparam int WORD_W          = 32;
   localparam int SLOT_W          = 3;
   localparam int REQ_PRIO_W      = 5;

   typedef enum logic [2:0] {
      OP_CREATE      = 3'd0,
      OP_DELAY       = 3'd1,
      OP_DELAY_UNTIL = 3'd2,
      OP_SUSPEND     = 3'd3,
      OP_RESUME      = 3'd4,
      OP_DELETE      = 3'd5,
      OP_START       = 3'd6,
      OP_SCHEDULE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_IDLE  = 2'd2,
      ST_LIMIT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_TICK,
      S_DU_CHECK,
      S_DU_FIX,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type                  operation;
      logic [SLOT_W-1:0]       task_slot;
      logic [REQ_PRIO_W-1:0]   priority_req;
      logic [WORD_W-1:0]       ticks;
      logic [WORD_W-1:0]       previous_wake;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_W-1:0]       granted_task;
      logic [WORD_W-1:0]       next_wake;
      logic [WORD_W-1:0]       current_tick;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic              carry;
   } alu_rsp_type;

endpackage

@@ design/priority_task_scheduler.sv @@
// Each request passes from the idle state through an execute step to the response register;
// delay_until adds a check step and possibly a fix step, create, start and a granting schedule
// scan the task table (one entry per cycle), and a schedule that finds no ready task adds an idle tick.
// One request is handled at a time, taken in the cycle after the previous result has moved to
// the response register; the register holds it until taken.
// Reset (synchronous, active high) clears the task table, the tick and the tick limit.
// Top level of the priority task scheduler.
`timescale 1ns / 1ps

module priority_task_scheduler
   import pts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WORD_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   logic [WORD_W-1:0] limit_ff, limit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              core_valid;
   logic              core_ready;
   rsp_type           core_rsp;

   pts_core u_core (
      .clock      (clock),
      .reset      (reset),
      .tick_limit (limit_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_data   (core_rsp)
   );

   assign csr_ready  = 1'b1;
   assign core_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (core_valid && core_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

@@ design/pts_alu.sv @@
// Shared 32-bit add/subtract unit with carry out.
`timescale 1ns / 1ps

module pts_alu
   import pts_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [WORD_W:0] total;

   // sub: a + ~b + 1, carry set means a >= b unsigned
   assign total = {1'b0, alu_req.a} + {1'b0, alu_req.b ^ {WORD_W{alu_req.sub}}}
                  + (WORD_W + 1)'(alu_req.sub);

   assign alu_rsp.sum   = total[WORD_W-1:0];
   assign alu_rsp.carry = total[WORD_W];

endmodule

@@ design/pts_core.sv @@
// Task table and sequencer; all tick and wake arithmetic goes through one shared adder.
`timescale 1ns / 1ps

module pts_core
   import pts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [WORD_W-1:0] tick_limit,
   input  logic              in_valid,
   output logic              in_ready,
   input  req_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rsp_type           out_data
);

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   slot_ok_ff, slot_ok_in;
   logic [PRIO_W-1:0]      prio_ff, prio_in;
   logic [WORD_W-1:0]      ticks_ff, ticks_in;
   logic [WORD_W-1:0]      prev_ff, prev_in;
   logic [WORD_W-1:0]      next_ff, next_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic [PRIO_W-1:0]      best_prio_ff, best_prio_in;
   status_type             status_ff, status_in;
   logic [IDX_W-1:0]       granted_ff, granted_in;
   logic [WORD_W-1:0]      wake_out_ff, wake_out_in;
   logic [WORD_W-1:0]      tick_ff, tick_in;

   logic [TASKS-1:0]       used_ff, used_in;
   logic [TASKS-1:0]       blocked_ff, blocked_in;
   logic [TASKS-1:0]       susp_ff, susp_in;
   logic [PRIO_W-1:0]      prio_tbl_ff [TASKS];
   logic [PRIO_W-1:0]      prio_tbl_in [TASKS];
   logic [WORD_W-1:0]      wake_ff [TASKS];
   logic [WORD_W-1:0]      wake_in [TASKS];

   alu_req_type            alu_req;
   alu_rsp_type            alu_rsp;

   logic                   last;
   logic                   unblock;
   logic                   blk_next;
   logic                   eligible;
   logic                   take;

   pts_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign last     = (idx_ff == IDX_W'(TASKS - 1));
   // wake check for the scanned entry uses the adder result tick - wake
   assign unblock  = used_ff[idx_ff] && !susp_ff[idx_ff] && blocked_ff[idx_ff] &&
                     !alu_rsp.sum[WORD_W-1];
   assign blk_next = blocked_ff[idx_ff] && !unblock;
   assign eligible = used_ff[idx_ff] && !blk_next && !susp_ff[idx_ff];
   assign take     = eligible && (!found_ff || (prio_tbl_ff[idx_ff] > best_prio_ff));

   assign out_data.status       = status_ff;
   assign out_data.granted_task = SLOT_W'(granted_ff);
   assign out_data.next_wake    = wake_out_ff;
   assign out_data.current_tick = tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tick_ff    <= '0;
         used_ff    <= '0;
         blocked_ff <= '0;
         susp_ff    <= '0;
         for (int i = 0; i < TASKS; i++) begin
            prio_tbl_ff[i] <= '0;
            wake_ff[i]     <= '0;
         end
      end else begin
         state_ff   <= state_in;
         tick_ff    <= tick_in;
         used_ff    <= used_in;
         blocked_ff <= blocked_in;
         susp_ff    <= susp_in;
         for (int i = 0; i < TASKS; i++) begin
            prio_tbl_ff[i] <= prio_tbl_in[i];
            wake_ff[i]     <= wake_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      slot_ok_ff   <= slot_ok_in;
      prio_ff      <= prio_in;
      ticks_ff     <= ticks_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      wake_out_ff  <= wake_out_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      prio_in      = prio_ff;
      ticks_in     = ticks_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      wake_out_in  = wake_out_ff;
      tick_in      = tick_ff;
      used_in      = used_ff;
      blocked_in   = blocked_ff;
      susp_in      = susp_ff;
      prio_tbl_in  = prio_tbl_ff;
      wake_in      = wake_ff;
      alu_req      = '{a: tick_ff, b: ticks_ff, sub: 1'b0};
      in_ready     = 1'b0;
      out_valid    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in       = in_data.operation;
               slot_in     = IDX_W'(in_data.task_slot);
               slot_ok_in  = int'(in_data.task_slot) < TASKS;
               if (int'(in_data.priority_req) >= PRIORITY_LEVELS) begin
                  prio_in = PRIO_W'(PRIORITY_LEVELS - 1);
               end else begin
                  prio_in = PRIO_W'(in_data.priority_req);
               end
               ticks_in     = in_data.ticks;
               prev_in      = in_data.previous_wake;
               idx_in       = '0;
               found_in     = 1'b0;
               best_in      = '0;
               best_prio_in = '0;
               status_in    = ST_OK;
               granted_in   = '0;
               wake_out_in  = '0;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_CREATE, OP_START: begin
                  state_in = S_SCAN;
               end
               OP_DELAY: begin
                  alu_req.b = (ticks_ff == '0) ? WORD_W'(1) : ticks_ff;
                  if (slot_ok_ff) begin
                     wake_in[slot_ff]    = alu_rsp.sum;
                     blocked_in[slot_ff] = 1'b1;
                  end
                  state_in = S_DONE;
               end
               OP_DELAY_UNTIL: begin
                  alu_req.a = prev_ff;
                  next_in   = alu_rsp.sum;
                  state_in  = slot_ok_ff ? S_DU_CHECK : S_DONE;
               end
               OP_SUSPEND: begin
                  if (slot_ok_ff) begin
                     susp_in[slot_ff]    = 1'b1;
                     blocked_in[slot_ff] = 1'b1;
                  end
                  state_in = S_DONE;
               end
               OP_RESUME: begin
                  if (slot_ok_ff) begin
                     susp_in[slot_ff]    = 1'b0;
                     blocked_in[slot_ff] = 1'b0;
                  end
                  state_in = S_DONE;
               end
               OP_DELETE: begin
                  if (slot_ok_ff) begin
                     used_in[slot_ff]    = 1'b0;
                     blocked_in[slot_ff] = 1'b1;
                  end
                  state_in = S_DONE;
               end
               OP_SCHEDULE: begin
                  // tick >= limit when tick - limit does not borrow
                  alu_req.b   = tick_limit;
                  alu_req.sub = 1'b1;
                  if ((tick_limit != '0) && alu_rsp.carry) begin
                     status_in = ST_LIMIT;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            case (op_ff)
               OP_CREATE: begin
                  if (!used_ff[idx_ff]) begin
                     used_in[idx_ff]     = 1'b1;
                     blocked_in[idx_ff]  = 1'b0;
                     susp_in[idx_ff]     = 1'b0;
                     prio_tbl_in[idx_ff] = prio_ff;
                     wake_in[idx_ff]     = '0;
                     granted_in          = idx_ff;
                     status_in           = ST_OK;
                     state_in            = S_DONE;
                  end else if (last) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               OP_START: begin
                  if (used_ff[idx_ff]) begin
                     blocked_in[idx_ff] = 1'b0;
                     wake_in[idx_ff]    = tick_ff;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  alu_req.b          = wake_ff[idx_ff];
                  alu_req.sub        = 1'b1;
                  blocked_in[idx_ff] = blk_next;
                  if (take) begin
                     found_in     = 1'b1;
                     best_in      = idx_ff;
                     best_prio_in = prio_tbl_ff[idx_ff];
                  end
                  if (last) begin
                     if (found_ff || take) begin
                        granted_in = take ? idx_ff : best_ff;
                        state_in   = S_DONE;
                     end else begin
                        state_in = S_TICK;
                     end
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            endcase
         end
         S_TICK: begin
            alu_req.b = WORD_W'(1);
            tick_in   = alu_rsp.sum;
            status_in = ST_IDLE;
            state_in  = S_DONE;
         end
         S_DU_CHECK: begin
            // behind schedule when next - tick <= 0
            alu_req.a   = next_ff;
            alu_req.b   = tick_ff;
            alu_req.sub = 1'b1;
            if ((alu_rsp.sum == '0) || alu_rsp.sum[WORD_W-1]) begin
               state_in = S_DU_FIX;
            end else begin
               wake_in[slot_ff]    = next_ff;
               blocked_in[slot_ff] = 1'b1;
               wake_out_in         = next_ff;
               state_in            = S_DONE;
            end
         end
         S_DU_FIX: begin
            wake_in[slot_ff]    = alu_rsp.sum;
            blocked_in[slot_ff] = 1'b1;
            wake_out_in         = alu_rsp.sum;
            state_in            = S_DONE;
         end
         S_DONE: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not start execution");

   a_tick_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_TICK) |=> (tick_ff == $past(tick_ff)))
      else $error("tick changed outside the idle tick step");

   a_limit_needs_limit: assert property (@(posedge clock) disable iff (reset)
      (out_valid && (status_ff == ST_LIMIT)) |-> (tick_limit != '0))
      else $error("limit status with no tick limit set");

   a_grant_ready: assert property (@(posedge clock) disable iff (reset)
      (out_valid && (op_ff == OP_SCHEDULE) && (status_ff == ST_OK)) |->
      (used_ff[granted_ff] && !blocked_ff[granted_ff] && !susp_ff[granted_ff]))
      else $error("granted task is not ready");

   a_create_used: assert property (@(posedge clock) disable iff (reset)
      (out_valid && (op_ff == OP_CREATE) && (status_ff == ST_OK)) |->
      used_ff[granted_ff])
      else $error("created slot not marked used");
`endif

endmodule
